@@ src/sd_card_spi_host_sequencer_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SD_CARD_SPI_HOST_SEQUENCER_TOP_ASSERT_SVH
`define SD_CARD_SPI_HOST_SEQUENCER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SDS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SDS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/sds_pkg.sv @@
`default_nettype none
package sds_pkg;
  localparam int unsigned DummyBytes = 25;
  localparam int unsigned BusyWait = 1000;

  typedef enum logic [5:0] {
    PH_IDLE = 6'd0, PH_DUMMY = 6'd1, PH_R7 = 6'd2, PH_OCR = 6'd3, PH_TOKEN = 6'd4,
    PH_RDATA = 6'd5, PH_RCRC = 6'd6, PH_WTOKEN = 6'd7, PH_WDATA = 6'd8,
    PH_WCRC = 6'd9, PH_WRESP = 6'd10, PH_BUSY = 6'd11, PH_CMD = 6'd16
  } phase_e;

  typedef enum logic [2:0] {
    C_GO_IDLE = 3'd0, C_IF_COND = 3'd1, C_APP = 3'd2, C_OP_COND = 3'd3,
    C_OCR = 3'd4, C_RD = 3'd5, C_WR = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0, MODE_READ = 2'd1, MODE_WRITE = 2'd2, MODE_XCHG = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_NOT_READY = 4'd1, ST_IDLE_FAIL = 4'd2, ST_COND_FAIL = 4'd3,
    ST_INIT_REJECT = 4'd4, ST_INIT_TIMEOUT = 4'd5, ST_CMD_REJECT = 4'd6,
    ST_TOKEN_TIMEOUT = 4'd7, ST_DATA_REJECT = 4'd8, ST_BUSY_TIMEOUT = 4'd9
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       exchange_wanted;
    logic       chip_select_n;
    logic       fast_clock;
    logic [7:0] read_data;
    logic       read_valid;
    logic       sector_end;
    logic       need_payload;
    logic       done_res;
    logic [3:0] status;
    logic       card_ready;
    logic       high_capacity;
  } result_t;

  function automatic logic [7:0] cmd_code(input logic [2:0] id);
    case (id)
      C_GO_IDLE: cmd_code = 8'd0;
      C_IF_COND: cmd_code = 8'd8;
      C_APP:     cmd_code = 8'd55;
      C_OP_COND: cmd_code = 8'd41;
      C_OCR:     cmd_code = 8'd58;
      C_RD:      cmd_code = 8'd17;
      C_WR:      cmd_code = 8'd24;
      default:   cmd_code = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] cmd_crc(input logic [2:0] id);
    case (id)
      C_GO_IDLE: cmd_crc = 8'h95;
      C_IF_COND: cmd_crc = 8'h87;
      default:   cmd_crc = 8'h01;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ src/sds_step.sv @@
`default_nettype none
// Next-state and result logic for one beat.
module sds_step #(
  parameter int unsigned ReadyWait    = 500,
  parameter int unsigned ResponseWait = 50,
  parameter int unsigned TokenTimeout = 8000,
  parameter int unsigned InitRetries  = 1000,
  parameter int unsigned IdleTries    = 10
) (
  input  wire sds_pkg::item_t   item_i,
  input  wire logic [5:0]       phase_i,
  input  wire logic [12:0]      wait_i,
  input  wire logic [9:0]       retry_i,
  input  wire logic [9:0]       idx_i,
  input  wire logic [31:0]      shift_i,
  input  wire logic [31:0]      sector_i,
  input  wire logic [15:0]      left_i,
  input  wire logic             v2_i,
  input  wire logic             ready_i,
  input  wire logic             blk_i,
  output logic [5:0]            phase_o,
  output logic [12:0]           wait_o,
  output logic [9:0]            retry_o,
  output logic [9:0]            idx_o,
  output logic [31:0]           shift_o,
  output logic [31:0]           sector_o,
  output logic [15:0]           left_o,
  output logic                  v2_o,
  output logic                  ready_o,
  output logic                  blk_o,
  output sds_pkg::result_t      res_o
);
  localparam logic [12:0] ReadyW = 13'(ReadyWait);
  localparam logic [12:0] RespW  = 13'(ResponseWait);
  localparam logic [12:0] TokW   = 13'(TokenTimeout);
  localparam logic [9:0]  InitR  = 10'(InitRetries);
  localparam logic [9:0]  IdleT  = 10'(IdleTries);
  localparam logic [9:0]  SecLast = 10'd511;
  localparam logic [9:0]  BusyW  = 10'(sds_pkg::BusyWait);
  localparam logic [9:0]  DummyN = 10'(sds_pkg::DummyBytes);

  logic [2:0]  id, rid;
  logic [1:0]  sub;
  logic [5:0]  rel;
  logic [31:0] arg, rarg;
  logic [7:0]  resp, fb;
  logic [12:0] w1;
  logic [9:0]  i1, r1;
  logic [15:0] l1;
  logic        resp_go;

  // Argument for the command being sent.
  always_comb begin
    rid = id;
    case (rid)
      sds_pkg::C_IF_COND: rarg = 32'h1AA;
      sds_pkg::C_OP_COND: rarg = v2_i ? 32'h4000_0000 : 32'd0;
      sds_pkg::C_RD, sds_pkg::C_WR: rarg = blk_i ? sector_i : {sector_i[22:0], 9'd0};
      default: rarg = 32'd0;
    endcase
    arg = rarg;
  end

  always_comb begin
    rel = phase_i - 6'(sds_pkg::PH_CMD);
    id  = rel[4:2];
    sub = rel[1:0];
    w1  = wait_i + 13'd1;
    i1  = idx_i + 10'd1;
    r1  = retry_i - 10'd1;
    l1  = left_i - 16'd1;
    resp_go = 1'b0;
    resp = item_i.miso_byte;
    case (i1[2:0])
      3'd1: fb = arg[31:24];
      3'd2: fb = arg[23:16];
      3'd3: fb = arg[15:8];
      3'd4: fb = arg[7:0];
      default: fb = sds_pkg::cmd_crc(id);
    endcase

    phase_o = phase_i; wait_o = wait_i; retry_o = retry_i; idx_o = idx_i;
    shift_o = shift_i; sector_o = sector_i; left_o = left_i;
    v2_o = v2_i; ready_o = ready_i; blk_o = blk_i;
    res_o = '0;
    res_o.mosi_byte = 8'hFF;
    res_o.chip_select_n = 1'b1;

    case (item_i.mode)
      sds_pkg::MODE_INIT: begin
        ready_o = 1'b0; blk_o = 1'b0; v2_o = 1'b0;
        phase_o = 6'(sds_pkg::PH_DUMMY); idx_o = '0;
        res_o.exchange_wanted = 1'b1;
      end
      sds_pkg::MODE_READ, sds_pkg::MODE_WRITE: begin
        phase_o = 6'(sds_pkg::PH_IDLE);
        if (!ready_i) begin
          res_o.done_res = 1'b1; res_o.status = sds_pkg::ST_NOT_READY;
        end else begin
          sector_o = item_i.sector; left_o = item_i.block_count;
          if (item_i.block_count == 16'd0) begin
            res_o.done_res = 1'b1;
          end else begin
            phase_o = 6'(sds_pkg::PH_CMD) + ((item_i.mode == sds_pkg::MODE_READ) ?
                      6'd20 : 6'd24);
            wait_o = '0; idx_o = '0;
            res_o.exchange_wanted = 1'b1; res_o.chip_select_n = 1'b0;
          end
        end
      end
      default: begin
        res_o.chip_select_n = 1'b0;
        res_o.exchange_wanted = 1'b1;
        case (phase_i)
          sds_pkg::PH_IDLE: begin
            res_o.exchange_wanted = 1'b0; res_o.chip_select_n = 1'b1;
          end
          sds_pkg::PH_DUMMY: begin
            idx_o = i1;
            if (i1 < DummyN) res_o.chip_select_n = 1'b1;
            else begin
              retry_o = '0; phase_o = 6'(sds_pkg::PH_CMD); wait_o = '0; idx_o = '0;
            end
          end
          sds_pkg::PH_R7, sds_pkg::PH_OCR: begin
            shift_o = {shift_i[23:0], item_i.miso_byte};
            idx_o = i1;
            if (i1 >= 10'd4) begin
              if (phase_i == 6'(sds_pkg::PH_R7)) begin
                if (shift_o[7:0] != 8'hAA) begin
                  phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                  res_o.status = sds_pkg::ST_COND_FAIL;
                end else begin
                  v2_o = 1'b1; retry_o = InitR;
                  phase_o = 6'(sds_pkg::PH_CMD) + 6'd8; wait_o = '0; idx_o = '0;
                end
              end else begin
                blk_o = shift_o[30]; ready_o = 1'b1;
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
              end
            end
          end
          sds_pkg::PH_TOKEN: begin
            if (item_i.miso_byte == 8'hFE) begin
              phase_o = 6'(sds_pkg::PH_RDATA); idx_o = '0;
            end else begin
              wait_o = wait_i - 13'd1;
              if (wait_o == '0) begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                res_o.status = sds_pkg::ST_TOKEN_TIMEOUT;
              end
            end
          end
          sds_pkg::PH_RDATA: begin
            res_o.read_data = item_i.miso_byte; res_o.read_valid = 1'b1;
            res_o.sector_end = (idx_i == SecLast);
            idx_o = i1;
            if (idx_i == SecLast) begin
              phase_o = 6'(sds_pkg::PH_RCRC); idx_o = '0;
            end
          end
          sds_pkg::PH_RCRC: begin
            idx_o = i1;
            if (i1 >= 10'd2) begin
              sector_o = sector_i + 32'd1; left_o = l1;
              if (l1 == '0) begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
              end else begin
                phase_o = 6'(sds_pkg::PH_CMD) + 6'd20; wait_o = '0; idx_o = '0;
              end
            end
          end
          sds_pkg::PH_WTOKEN: begin
            phase_o = 6'(sds_pkg::PH_WDATA); idx_o = '0;
            res_o.mosi_byte = item_i.write_byte; res_o.need_payload = 1'b1;
          end
          sds_pkg::PH_WDATA: begin
            idx_o = i1;
            if (idx_i != SecLast) begin
              res_o.mosi_byte = item_i.write_byte;
              res_o.need_payload = (i1 != SecLast);
            end else begin
              phase_o = 6'(sds_pkg::PH_WCRC); idx_o = '0;
            end
          end
          sds_pkg::PH_WCRC: begin
            idx_o = i1;
            if (i1 >= 10'd2) phase_o = 6'(sds_pkg::PH_WRESP);
          end
          sds_pkg::PH_WRESP: begin
            if (item_i.miso_byte[4:0] != 5'h05) begin
              phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
              res_o.status = sds_pkg::ST_DATA_REJECT;
            end else begin
              phase_o = 6'(sds_pkg::PH_BUSY); retry_o = BusyW;
            end
          end
          sds_pkg::PH_BUSY: begin
            if (item_i.miso_byte != 8'h00) begin
              sector_o = sector_i + 32'd1; left_o = l1;
              if (l1 == '0) begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
              end else begin
                phase_o = 6'(sds_pkg::PH_CMD) + 6'd24; wait_o = '0; idx_o = '0;
              end
            end else begin
              retry_o = r1;
              if (r1 == '0) begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                res_o.status = sds_pkg::ST_BUSY_TIMEOUT;
              end
            end
          end
          default: begin
            if (phase_i >= 6'd16 && phase_i < 6'd44 && sub != 2'd3) begin
              if (sub == 2'd0) begin
                wait_o = w1;
                if (item_i.miso_byte == 8'hFF || w1 >= ReadyW) begin
                  phase_o = phase_i + 6'd1; idx_o = '0;
                  res_o.mosi_byte = 8'h40 | sds_pkg::cmd_code(id);
                end
              end else if (sub == 2'd1) begin
                idx_o = i1;
                if (i1 < 10'd6) res_o.mosi_byte = fb;
                else begin
                  phase_o = phase_i + 6'd1; wait_o = '0;
                end
              end else begin
                if (!item_i.miso_byte[7]) resp_go = 1'b1;
                else begin
                  wait_o = w1;
                  if (w1 >= RespW) begin
                    resp_go = 1'b1; resp = 8'hFF;
                  end
                end
              end
            end else begin
              phase_o = 6'(sds_pkg::PH_IDLE);
              res_o.exchange_wanted = 1'b0; res_o.chip_select_n = 1'b1;
            end
          end
        endcase

        if (resp_go) begin
          // Command response handling; default handles read and write, rejecting a nonzero response.
          case (id)
            sds_pkg::C_GO_IDLE: begin
              if (resp == 8'h01) begin
                phase_o = 6'(sds_pkg::PH_CMD) + 6'd4; wait_o = '0; idx_o = '0;
              end else begin
                retry_o = retry_i + 10'd1;
                if (retry_o >= IdleT) begin
                  phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                  res_o.status = sds_pkg::ST_IDLE_FAIL;
                end else begin
                  phase_o = 6'(sds_pkg::PH_CMD); wait_o = '0; idx_o = '0;
                end
              end
            end
            sds_pkg::C_IF_COND: begin
              if (resp == 8'h01) begin
                phase_o = 6'(sds_pkg::PH_R7); idx_o = '0; shift_o = '0;
              end else if (resp == 8'h05) begin
                v2_o = 1'b0; retry_o = InitR;
                phase_o = 6'(sds_pkg::PH_CMD) + 6'd8; wait_o = '0; idx_o = '0;
              end else begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                res_o.status = sds_pkg::ST_COND_FAIL;
              end
            end
            sds_pkg::C_APP, sds_pkg::C_OP_COND: begin
              if (id == 3'(sds_pkg::C_OP_COND) && resp == 8'h00) begin
                if (v2_i) begin
                  phase_o = 6'(sds_pkg::PH_CMD) + 6'd16; wait_o = '0; idx_o = '0;
                end else begin
                  blk_o = 1'b0; ready_o = 1'b1;
                  phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                end
              end else if (id == 3'(sds_pkg::C_OP_COND) && resp != 8'h01) begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                res_o.status = sds_pkg::ST_INIT_REJECT;
              end else if (id == 3'(sds_pkg::C_APP) && resp <= 8'h01) begin
                phase_o = 6'(sds_pkg::PH_CMD) + 6'd12; wait_o = '0; idx_o = '0;
              end else begin
                retry_o = r1;
                if (r1 == '0) begin
                  phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                  res_o.status = sds_pkg::ST_INIT_TIMEOUT;
                end else begin
                  phase_o = 6'(sds_pkg::PH_CMD) + 6'd8; wait_o = '0; idx_o = '0;
                end
              end
            end
            sds_pkg::C_OCR: begin
              if (resp == 8'h00) begin
                phase_o = 6'(sds_pkg::PH_OCR); idx_o = '0; shift_o = '0;
              end else begin
                blk_o = 1'b0; ready_o = 1'b1;
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
              end
            end
            default: begin
              if (resp != 8'h00) begin
                phase_o = 6'(sds_pkg::PH_IDLE); res_o.done_res = 1'b1;
                res_o.status = sds_pkg::ST_CMD_REJECT;
              end else if (id == 3'(sds_pkg::C_RD)) begin
                phase_o = 6'(sds_pkg::PH_TOKEN); wait_o = TokW;
              end else begin
                phase_o = 6'(sds_pkg::PH_WTOKEN);
                res_o.mosi_byte = 8'hFE; res_o.need_payload = 1'b1;
              end
            end
          endcase
        end
        if (res_o.done_res) begin
          res_o.exchange_wanted = 1'b0; res_o.chip_select_n = 1'b1;
          res_o.mosi_byte = 8'hFF;
        end
      end
    endcase
    res_o.card_ready = ready_o;
    res_o.fast_clock = ready_o;
    res_o.high_capacity = blk_o;
  end
endmodule
`default_nettype wire

@@ src/sd_card_spi_host_sequencer_top.sv @@
// Results are registered in the output register, or in the skid stage on a stall.
// Throughput: one input beat per cycle while the skid stage is empty; the output
// register and skid stage let a beat enter while an earlier one waits downstream.
// Reset (rst_ni low, asynchronous) puts the sequencer idle, clears all counters,
// capacity and ready flags, and empties the output stages.
`default_nettype none
module sd_card_spi_host_sequencer_top #(
  parameter int unsigned READY_WAIT    = 500,
  parameter int unsigned RESPONSE_WAIT = 50,
  parameter int unsigned TOKEN_TIMEOUT = 8000,
  parameter int unsigned INIT_RETRIES  = 1000,
  parameter int unsigned IDLE_TRIES    = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: sector[31:0], block_count[47:32], miso_byte[55:48], write_byte[63:56].
  input  wire logic [63:0] s_axis_tdata_i,
  // tuser: mode[1:0].
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: mosi_byte[7:0], exchange_wanted[8], chip_select_n[9], fast_clock[10],
  // read_data[18:11], need_payload[19], done_res[20], status[24:21],
  // card_ready[25], high_capacity[26], zeros above.
  output logic [31:0]      m_axis_tdata_o,
  // tlast: sector_end, set on the last payload beat of a read sector.
  output logic             m_axis_tlast_o,
  // tuser: read_valid.
  output logic             m_axis_tuser_o
);
  // The sequencer state advances as a beat is accepted; the combinational step
  // sits between the state registers and the result register.
  sds_pkg::item_t   item;
  sds_pkg::result_t res_d, res_q, skid_q;
  logic             out_v_q, skid_v_q, acc;

  logic [5:0]  phase_q, phase_d;
  logic [12:0] wait_q, wait_d;
  logic [9:0]  retry_q, retry_d, idx_q, idx_d;
  logic [31:0] shift_q, shift_d, sector_q, sector_d;
  logic [15:0] left_q, left_d;
  logic        v2_q, v2_d, ready_q, ready_d, blk_q, blk_d;

  assign item.mode        = s_axis_tuser_i;
  assign item.sector      = s_axis_tdata_i[31:0];
  assign item.block_count = s_axis_tdata_i[47:32];
  assign item.miso_byte   = s_axis_tdata_i[55:48];
  assign item.write_byte  = s_axis_tdata_i[63:56];

  // Ready while the skid stage is empty.
  assign s_axis_tready_o = !skid_v_q;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  sds_step #(
    .ReadyWait(READY_WAIT), .ResponseWait(RESPONSE_WAIT), .TokenTimeout(TOKEN_TIMEOUT),
    .InitRetries(INIT_RETRIES), .IdleTries(IDLE_TRIES)
  ) u_step (
    .item_i(item), .phase_i(phase_q), .wait_i(wait_q), .retry_i(retry_q),
    .idx_i(idx_q), .shift_i(shift_q), .sector_i(sector_q), .left_i(left_q),
    .v2_i(v2_q), .ready_i(ready_q), .blk_i(blk_q),
    .phase_o(phase_d), .wait_o(wait_d), .retry_o(retry_d), .idx_o(idx_d),
    .shift_o(shift_d), .sector_o(sector_d), .left_o(left_d),
    .v2_o(v2_d), .ready_o(ready_d), .blk_o(blk_d), .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 6'(sds_pkg::PH_IDLE);
      wait_q <= '0; retry_q <= '0; idx_q <= '0; shift_q <= '0;
      sector_q <= '0; left_q <= '0; v2_q <= 1'b0; ready_q <= 1'b0; blk_q <= 1'b0;
    end else if (acc) begin
      phase_q <= phase_d; wait_q <= wait_d; retry_q <= retry_d; idx_q <= idx_d;
      shift_q <= shift_d; sector_q <= sector_d; left_q <= left_d;
      v2_q <= v2_d; ready_q <= ready_d; blk_q <= blk_d;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || m_axis_tready_i) begin
        out_v_q <= skid_v_q || acc;
        skid_v_q <= 1'b0;
      end else if (acc) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready_i) begin
      res_q <= skid_v_q ? skid_q : res_d;
    end else if (acc) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = {5'd0, res_q.high_capacity, res_q.card_ready, res_q.status,
                           res_q.done_res, res_q.need_payload, res_q.read_data,
                           res_q.fast_clock, res_q.chip_select_n, res_q.exchange_wanted,
                           res_q.mosi_byte};
  assign m_axis_tlast_o = res_q.sector_end;
  assign m_axis_tuser_o = res_q.read_valid;
endmodule
`default_nettype wire

@@ src/sds_checker.sv @@
`default_nettype none
`include "sd_card_spi_host_sequencer_top_assert.svh"
module sds_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic        m_axis_tuser_o
);
  logic [33:0] out_beat;
  logic        out_wait, in_fire, out_done, out_idle;

  assign out_beat = {m_axis_tuser_o, m_axis_tlast_o, m_axis_tdata_o};
  assign out_wait = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_done = m_axis_tvalid_o && m_axis_tdata_o[20];
  assign out_idle = !m_axis_tdata_o[8] && m_axis_tdata_o[9];

  `SDS_ASSERT_NXT(a_hold, clk_i, rst_ni, out_wait, m_axis_tvalid_o && $stable(out_beat))
  `SDS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, out_done, out_idle)
  `SDS_ASSERT_IMP(a_fast, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[10] == m_axis_tdata_o[25])
  `SDS_ASSERT_NXT(a_out, clk_i, rst_ni, in_fire, m_axis_tvalid_o)
endmodule
bind sd_card_spi_host_sequencer_top sds_checker u_sds_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o), .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i), .m_axis_tdata_o(m_axis_tdata_o),
  .m_axis_tlast_o(m_axis_tlast_o), .m_axis_tuser_o(m_axis_tuser_o)
);
`default_nettype wire
